// ===== rtl/core/irpw_pkg.sv =====
`default_nettype none

package irpw_pkg;

   // Operation codes carried on the request channel.
   localparam logic [1:0] OP_EDGE  = 2'd0;
   localparam logic [1:0] OP_ARM   = 2'd1;
   localparam logic [1:0] OP_CLOSE = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   localparam int MAX_ENTRIES_DEF = 256;

   localparam int TIMER_W = 24;
   localparam int INDEX_W = 8;
   localparam int DUR_W   = 20;
   localparam int COUNT_W = 9;

   // Half of the masked timer difference; this is what gets divided by 25.
   localparam int SPAN_W  = 24;
   // A stored entry: level, then the span without its two always-zero bits.
   localparam int ENTRY_W = 23;

   localparam logic [TIMER_W:0] WRAP_ADD = 25'h0C00000;

   // ceil(2^29 / 25): exact floor division by 25 for any 24-bit span.
   localparam int           RECIP_W     = 25;
   localparam logic [24:0]  RECIP_25    = 25'd21474837;
   localparam int           RECIP_SHIFT = 29;
   localparam int           PROD_W      = SPAN_W + RECIP_W;

   typedef struct packed {
      logic                appended;
      logic                level;
      logic                valid;
      logic                from_ram;
      logic [COUNT_W-1:0]  count;
      logic                active;
      logic [SPAN_W-1:0]   span;
   } rec_type;

   function automatic logic [ENTRY_W-1:0] pack_entry(input logic level,
                                                     input logic [SPAN_W-1:0] span);
      pack_entry = {level, span[SPAN_W-1], span[SPAN_W-4:0]};
   endfunction

   function automatic logic [SPAN_W-1:0] unpack_span(input logic [ENTRY_W-1:0] entry);
      unpack_span = {entry[ENTRY_W-2], 2'b00, entry[ENTRY_W-3:0]};
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/irpw_ram.sv =====
`default_nettype none

module irpw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/irpw_ctrl.sv =====
`default_nettype none

module irpw_ctrl
   import irpw_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           accept,
   input  wire logic [1:0]                     operation,
   input  wire logic                           pin_level,
   input  wire logic [TIMER_W-1:0]             timer_value,
   input  wire logic [INDEX_W-1:0]             read_index,
   output rec_type                             rec,
   output logic                                wr_en,
   output logic [$clog2(MAX_ENTRIES)-1:0]      wr_addr,
   output logic [ENTRY_W-1:0]                  wr_data,
   output logic [$clog2(MAX_ENTRIES)-1:0]      rd_addr
);

   localparam int AW    = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

   logic               active_ff, active_in;
   logic               await_ff, await_in;
   logic               fell_ff, fell_in;
   logic               rose_ff, rose_in;
   logic [TIMER_W-1:0] fall_time_ff, fall_time_in;
   logic [TIMER_W-1:0] rise_time_ff, rise_time_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   logic [TIMER_W-1:0]     last_time;
   logic [TIMER_W:0]       span_sum;
   logic [SPAN_W-1:0]      span_n;
   logic                   room;
   logic                   in_range;
   logic                   append;
   logic [CNT_W+INDEX_W-1:0] cmp_count;
   logic [CNT_W+INDEX_W-1:0] cmp_index;
   logic [CNT_W+COUNT_W-1:0] count_wide;
   logic [AW+INDEX_W-1:0]    index_wide;

   // A rising edge closes a low period that began at the last fall, and the
   // other way round. Bits 22 and 23 of the wrapped difference are dropped.
   assign last_time = pin_level ? fall_time_ff : rise_time_ff;
   assign span_sum  = {1'b0, timer_value} + WRAP_ADD - {1'b0, last_time};
   assign span_n    = {span_sum[TIMER_W], 2'b00, span_sum[TIMER_W-3:1]};
   assign room      = count_ff < MAX_CNT;

   assign cmp_count = {{INDEX_W{1'b0}}, count_ff};
   assign cmp_index = {{CNT_W{1'b0}}, read_index};
   assign in_range  = cmp_index < cmp_count;

   always_comb begin
      active_in    = active_ff;
      await_in     = await_ff;
      fell_in      = fell_ff;
      rose_in      = rose_ff;
      fall_time_in = fall_time_ff;
      rise_time_in = rise_time_ff;
      count_in     = count_ff;
      append       = 1'b0;
      rec          = '0;
      unique case (operation)
         OP_EDGE: begin
            if (active_ff) begin
               if (!pin_level) begin
                  if (await_ff) begin
                     await_in     = 1'b0;
                     fall_time_in = timer_value;
                  end else if (rose_ff) begin
                     append       = room;
                     fall_time_in = timer_value;
                  end
                  fell_in = 1'b1;
                  rose_in = 1'b0;
               end else begin
                  if (fell_ff) begin
                     append       = room;
                     rise_time_in = timer_value;
                  end
                  fell_in = 1'b0;
                  rose_in = 1'b1;
               end
            end
         end
         OP_ARM: begin
            count_in  = '0;
            active_in = 1'b1;
            await_in  = 1'b1;
         end
         OP_CLOSE: begin
            active_in = 1'b0;
         end
         OP_READ: begin
            rec.from_ram = 1'b1;
            rec.valid    = in_range;
         end
      endcase
      if (append) begin
         count_in     = count_ff + 1'b1;
         rec.appended = 1'b1;
         rec.level    = ~pin_level;
         rec.span     = span_n;
      end
      rec.active = active_in;
      rec.count  = count_wide[COUNT_W-1:0];
   end

   assign count_wide = {{COUNT_W{1'b0}}, count_in};
   assign index_wide = {{AW{1'b0}}, read_index};

   assign wr_en   = accept && append;
   assign wr_addr = count_ff[AW-1:0];
   assign wr_data = pack_entry(~pin_level, span_n);
   assign rd_addr = index_wide[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         await_ff     <= 1'b0;
         fell_ff      <= 1'b0;
         rose_ff      <= 1'b0;
         fall_time_ff <= '0;
         rise_time_ff <= '0;
         count_ff     <= '0;
      end else if (accept) begin
         active_ff    <= active_in;
         await_ff     <= await_in;
         fell_ff      <= fell_in;
         rose_ff      <= rose_in;
         fall_time_ff <= fall_time_in;
         rise_time_ff <= rise_time_in;
         count_ff     <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/irpw_pipe.sv =====
`default_nettype none

module irpw_pipe
   import irpw_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire rec_type             rec,
   input  wire logic [ENTRY_W-1:0]  rd_data,
   input  wire logic                rsp_ready,
   output logic                     rsp_valid,
   output logic                     rsp_appended,
   output logic                     rsp_entry_level,
   output logic [DUR_W-1:0]         rsp_entry_duration,
   output logic                     rsp_entry_valid,
   output logic [COUNT_W-1:0]       rsp_entry_count,
   output logic                     rsp_capture_active
);

   logic en1, en2, en3;
   logic accept;

   logic         s1_valid_ff, s1_valid_in;
   rec_type      s1_rec_ff, s1_rec_in;

   logic               s2_valid_ff, s2_valid_in;
   logic               s2_appended_ff, s2_appended_in;
   logic               s2_level_ff, s2_level_in;
   logic               s2_hit_ff, s2_hit_in;
   logic [COUNT_W-1:0] s2_count_ff, s2_count_in;
   logic               s2_active_ff, s2_active_in;
   logic [PROD_W-1:0]  s2_product_ff, s2_product_in;

   logic               out_valid_ff, out_valid_in;
   logic               out_appended_ff, out_appended_in;
   logic               out_level_ff, out_level_in;
   logic [DUR_W-1:0]   out_duration_ff, out_duration_in;
   logic               out_hit_ff, out_hit_in;
   logic [COUNT_W-1:0] out_count_ff, out_count_in;
   logic               out_active_ff, out_active_in;

   logic              use_ram;
   logic [SPAN_W-1:0] mul_span;
   logic              mul_level;

   assign en3       = !out_valid_ff || rsp_ready;
   assign en2       = !s2_valid_ff || en3;
   assign en1       = !s1_valid_ff || en2;
   assign req_ready = en1;
   assign accept    = req_valid && en1;

   // Reads take level and span from the memory word present in stage one;
   // every other item carries its own (possibly zero) span.
   assign use_ram   = s1_rec_ff.from_ram && s1_rec_ff.valid;
   assign mul_span  = use_ram ? unpack_span(rd_data) : s1_rec_ff.span;
   assign mul_level = use_ram ? rd_data[ENTRY_W-1] : s1_rec_ff.level;

   always_comb begin
      s1_valid_in = en1 ? req_valid : s1_valid_ff;
      s1_rec_in   = accept ? rec : s1_rec_ff;

      s2_valid_in    = en2 ? s1_valid_ff : s2_valid_ff;
      s2_appended_in = s2_appended_ff;
      s2_level_in    = s2_level_ff;
      s2_hit_in      = s2_hit_ff;
      s2_count_in    = s2_count_ff;
      s2_active_in   = s2_active_ff;
      s2_product_in  = s2_product_ff;
      if (s1_valid_ff && en2) begin
         s2_appended_in = s1_rec_ff.appended;
         s2_level_in    = mul_level;
         s2_hit_in      = s1_rec_ff.valid;
         s2_count_in    = s1_rec_ff.count;
         s2_active_in   = s1_rec_ff.active;
         s2_product_in  = {{RECIP_W{1'b0}}, mul_span} * {{SPAN_W{1'b0}}, RECIP_25};
      end

      out_valid_in    = en3 ? s2_valid_ff : out_valid_ff;
      out_appended_in = out_appended_ff;
      out_level_in    = out_level_ff;
      out_duration_in = out_duration_ff;
      out_hit_in      = out_hit_ff;
      out_count_in    = out_count_ff;
      out_active_in   = out_active_ff;
      if (s2_valid_ff && en3) begin
         out_appended_in = s2_appended_ff;
         out_level_in    = s2_level_ff;
         out_duration_in = s2_product_ff[RECIP_SHIFT +: DUR_W];
         out_hit_in      = s2_hit_ff;
         out_count_in    = s2_count_ff;
         out_active_in   = s2_active_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_rec_ff       <= s1_rec_in;
      s2_appended_ff  <= s2_appended_in;
      s2_level_ff     <= s2_level_in;
      s2_hit_ff       <= s2_hit_in;
      s2_count_ff     <= s2_count_in;
      s2_active_ff    <= s2_active_in;
      s2_product_ff   <= s2_product_in;
      out_appended_ff <= out_appended_in;
      out_level_ff    <= out_level_in;
      out_duration_ff <= out_duration_in;
      out_hit_ff      <= out_hit_in;
      out_count_ff    <= out_count_in;
      out_active_ff   <= out_active_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_appended       = out_appended_ff;
   assign rsp_entry_level    = out_level_ff;
   assign rsp_entry_duration = out_duration_ff;
   assign rsp_entry_valid    = out_hit_ff;
   assign rsp_entry_count    = out_count_ff;
   assign rsp_capture_active = out_active_ff;

endmodule

`default_nettype wire

// ===== rtl/core/ir_pulse_width_recorder.sv =====
// Infrared pulse width recorder. Each request beat is an edge, arm, close or
// read operation, and each produces exactly one response beat, in order. The
// block takes one beat per clock unless a stalled response side backs it up,
// and moves each beat through the first and second stages and the response
// register; up to three beats are in flight. Recorded entries live in a
// single dual-port RAM of MAX_ENTRIES words that is written by an appending
// edge and read by a read operation in the cycle the beat is accepted, so a
// read placed right behind the append of the same entry already sees it. The
// RAM holds level and raw half-span; the divide by 50 is a reciprocal multiply
// in the second stage shared by appends and reads. The RAM is not cleared at
// reset: the entry count gates every read, so no clearing pass is needed and
// the block is ready right out of reset. Arm clears the count and waits for a
// first falling edge, which only sets the time reference; once the store is
// full, further appends are dropped without notice.

`default_nettype none

module ir_pulse_width_recorder
   import irpw_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [1:0]          req_operation,
   input  wire logic                req_pin_level,
   input  wire logic [TIMER_W-1:0]  req_timer_value,
   input  wire logic [INDEX_W-1:0]  req_read_index,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic                     rsp_appended,
   output logic                     rsp_entry_level,
   output logic [DUR_W-1:0]         rsp_entry_duration,
   output logic                     rsp_entry_valid,
   output logic [COUNT_W-1:0]       rsp_entry_count,
   output logic                     rsp_capture_active
);

   localparam int AW = $clog2(MAX_ENTRIES);

   logic               accept;
   rec_type            rec;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic [AW-1:0]      rd_addr;
   logic               rd_en;
   logic [ENTRY_W-1:0] rd_data;

   assign accept = req_valid && req_ready;
   assign rd_en  = accept && (req_operation == OP_READ);

   // Capture state and the append/read decisions for the beat being accepted.
   irpw_ctrl #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .operation   (req_operation),
      .pin_level   (req_pin_level),
      .timer_value (req_timer_value),
      .read_index  (req_read_index),
      .rec         (rec),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_addr     (rd_addr)
   );

   // Entry store: one write and one registered read per cycle.
   irpw_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_ENTRIES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Memory return, divide by 50 and the response register.
   irpw_pipe u_pipe (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .rec                (rec),
      .rd_data            (rd_data),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_appended       (rsp_appended),
      .rsp_entry_level    (rsp_entry_level),
      .rsp_entry_duration (rsp_entry_duration),
      .rsp_entry_valid    (rsp_entry_valid),
      .rsp_entry_count    (rsp_entry_count),
      .rsp_capture_active (rsp_capture_active)
   );

endmodule

`default_nettype wire

// ===== rtl/core/irpw_checker.sv =====
`default_nettype none

module irpw_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_appended,
   input wire logic        rsp_entry_level,
   input wire logic [19:0] rsp_entry_duration,
   input wire logic        rsp_entry_valid,
   input wire logic [8:0]  rsp_entry_count,
   input wire logic        rsp_capture_active
);

   logic       in_beat;
   logic       out_beat;
   logic [1:0] pending_ff, pending_in;
   logic [8:0] last_count_ff, last_count_in;

   assign in_beat  = req_valid && req_ready;
   assign out_beat = rsp_valid && rsp_ready;

   always_comb begin
      pending_in    = pending_ff;
      last_count_in = last_count_ff;
      priority if (in_beat && !out_beat) begin
         pending_in = pending_ff + 2'd1;
      end else if (out_beat && !in_beat) begin
         pending_in = pending_ff - 2'd1;
      end
      if (out_beat) begin
         last_count_in = rsp_entry_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff    <= '0;
         last_count_ff <= '0;
      end else begin
         pending_ff    <= pending_in;
         last_count_ff <= last_count_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_appended)
         && $stable(rsp_entry_level) && $stable(rsp_entry_duration)
         && $stable(rsp_entry_valid) && $stable(rsp_entry_count)
         && $stable(rsp_capture_active))
      else $error("response beat changed while stalled");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("response beat without an accepted request");

   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> pending_ff != 2'd0)
      else $error("request side stalled with nothing in flight");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      out_beat && rsp_appended |-> rsp_entry_count == last_count_ff + 9'd1)
      else $error("append did not advance the entry count by one");

endmodule

bind ir_pulse_width_recorder irpw_checker u_irpw_checker (.*);

`default_nettype wire

// ===== tb/ir_pulse_width_recorder_tb.sv =====
`timescale 1ns / 1ps

// Pin level carried by an edge beat: the level the pin settles to after the edge.
localparam bit PIN_FALL = 1'b0;
localparam bit PIN_RISE = 1'b1;

// One response beat, fields in port order.
typedef struct packed {
   logic                         appended;
   logic                         level;
   logic [irpw_pkg::DUR_W-1:0]   duration;
   logic                         valid;
   logic [irpw_pkg::COUNT_W-1:0] count;
   logic                         active;
} rsp_beat_type;

// Keeps its own copy of the capture state and the entry store, predicts the
// response of every accepted request beat and compares responses in order.
class pulse_scoreboard;
   rsp_beat_type awaited_rsp[$];
   bit          capturing;
   bit          want_first_fall;
   bit          saw_fall;
   bit          saw_rise;
   logic [23:0] fall_stamp;
   logic [23:0] rise_stamp;
   int unsigned stored;
   logic [20:0] entries [irpw_pkg::MAX_ENTRIES_DEF];
   int unsigned mismatches;
   int unsigned checked;
   int unsigned appends;
   int unsigned dropped;
   int unsigned read_hits;

   function new();
      fall_stamp = '0;
      rise_stamp = '0;
   endfunction

   // Timer span with the wrap offset folded in and bits 22 and 23 dropped,
   // in units of 50 ticks.
   function logic [19:0] span_units(input logic [23:0] now, input logic [23:0] last);
      logic [31:0] diff;
      diff = ({8'd0, now} + 32'h00C0_0000 - {8'd0, last}) & 32'h01FF_FFFF;
      diff = diff & ~32'h00C0_0000;
      return 20'(diff / 50);
   endfunction

   function void append_span(input bit level, input logic [19:0] units,
                             inout rsp_beat_type r);
      if (stored < irpw_pkg::MAX_ENTRIES_DEF) begin
         entries[stored] = {level, units};
         stored++;
         r.appended = 1'b1;
         r.level    = level;
         r.duration = units;
         appends++;
      end else begin
         dropped++;
      end
   endfunction

   function void note_request(input logic [1:0] op, input logic pin,
                              input logic [23:0] stamp, input logic [7:0] idx);
      rsp_beat_type r;
      r = '0;
      case (op)
         irpw_pkg::OP_EDGE: begin
            if (capturing) begin
               if (pin == PIN_FALL) begin
                  if (want_first_fall) begin
                     want_first_fall = 1'b0;
                     fall_stamp      = stamp;
                  end else if (saw_rise) begin
                     append_span(1'b1, span_units(stamp, rise_stamp), r);
                     fall_stamp = stamp;
                  end
                  saw_fall = 1'b1;
                  saw_rise = 1'b0;
               end else begin
                  if (saw_fall) begin
                     append_span(1'b0, span_units(stamp, fall_stamp), r);
                     rise_stamp = stamp;
                  end
                  saw_fall = 1'b0;
                  saw_rise = 1'b1;
               end
            end
         end
         irpw_pkg::OP_ARM: begin
            stored          = 0;
            capturing       = 1'b1;
            want_first_fall = 1'b1;
         end
         irpw_pkg::OP_CLOSE: begin
            capturing = 1'b0;
         end
         default: begin
            if (idx < stored) begin
               r.valid    = 1'b1;
               r.level    = entries[idx][20];
               r.duration = entries[idx][19:0];
               read_hits++;
            end
         end
      endcase
      r.count  = 9'(stored);
      r.active = capturing;
      awaited_rsp.push_back(r);
   endfunction

   function void report(input string field, input int unsigned want,
                        input int unsigned got_val);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: response %0d, %s mismatch: expected %0h, got %0h",
                  $time, checked, field, want, got_val);
   endfunction

   function void check_response(input rsp_beat_type got);
      rsp_beat_type want;
      if (awaited_rsp.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: response beat arrived with nothing outstanding", $time);
         return;
      end
      want = awaited_rsp.pop_front();
      if (got.appended !== want.appended) report("appended", want.appended, got.appended);
      if (got.level !== want.level) report("entry_level", want.level, got.level);
      if (got.duration !== want.duration)
         report("entry_duration", want.duration, got.duration);
      if (got.valid !== want.valid) report("entry_valid", want.valid, got.valid);
      if (got.count !== want.count) report("entry_count", want.count, got.count);
      if (got.active !== want.active) report("capture_active", want.active, got.active);
      checked++;
   endfunction
endclass

module ir_pulse_width_recorder_tb;
   import irpw_pkg::*;

   // Number of random request beats after the directed opening.
   localparam int ITEM_TARGET  = 1050;
   // Watchdog.
   localparam int CYCLE_LIMIT  = 100000;
   // Length of the one long response stall that backs the pipeline up.
   localparam int HOLD_CYCLES  = 80;
   // Settling time after the last expected response (pipeline is 3 deep).
   localparam int DRAIN_CYCLES = 20;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [1:0]          req_operation = OP_EDGE;
   logic                req_pin_level = 1'b0;
   logic [TIMER_W-1:0]  req_timer_value = '0;
   logic [INDEX_W-1:0]  req_read_index = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_appended;
   logic                rsp_entry_level;
   logic [DUR_W-1:0]    rsp_entry_duration;
   logic                rsp_entry_valid;
   logic [COUNT_W-1:0]  rsp_entry_count;
   logic                rsp_capture_active;

   pulse_scoreboard sb = new();

   int unsigned accepted_beats = 0;
   int unsigned offered_beats  = 0;
   int unsigned cycle_count    = 0;
   bit          pressure_done  = 1'b0;

   // Both sides stop idling for a stretch of the run so the block also sees
   // back-to-back traffic in both directions.
   wire calm_stretch = (accepted_beats >= 500) && (accepted_beats < 700);

   ir_pulse_width_recorder dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_pin_level      (req_pin_level),
      .req_timer_value    (req_timer_value),
      .req_read_index     (req_read_index),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_appended       (rsp_appended),
      .rsp_entry_level    (rsp_entry_level),
      .rsp_entry_duration (rsp_entry_duration),
      .rsp_entry_valid    (rsp_entry_valid),
      .rsp_entry_count    (rsp_entry_count),
      .rsp_capture_active (rsp_capture_active)
   );

   initial begin
      forever begin
         #2 clock = ~clock;
      end
   end

   // The watchdog ends a hung run. Nothing in this process follows the $finish.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Both channels are sampled at the rising edge, before the block's own
   // registers update, so every accepted beat is seen with its own payload.
   // A response can never come in the cycle its request is accepted, so the
   // order of the two calls below does not matter.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            sb.note_request(req_operation, req_pin_level, req_timer_value, req_read_index);
            accepted_beats++;
         end
         if (rsp_valid && rsp_ready)
            sb.check_response({rsp_appended, rsp_entry_level, rsp_entry_duration,
                               rsp_entry_valid, rsp_entry_count, rsp_capture_active});
      end
   end

   // Response side. It mostly accepts, drops ready about 8 percent of the time,
   // and once holds it low long enough that the block fills up and
   // has to push back on the request side.
   initial begin
      int unsigned hold;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (!pressure_done && accepted_beats >= 200) begin
            pressure_done = 1'b1;
            rsp_ready <= 1'b0;
            for (hold = 1; hold < HOLD_CYCLES; hold++) begin
               @(negedge clock);
               rsp_ready <= 1'b0;
            end
         end else begin
            rsp_ready <= calm_stretch || ($urandom_range(99) >= 8);
         end
      end
   end

   // Offers one request beat and returns once it has been accepted. A random
   // gap may come first; without one, valid stays high into the next beat and
   // only the payload changes at the falling edge.
   task automatic send_beat(input logic [1:0] op, input logic pin,
                            input logic [23:0] stamp, input logic [7:0] idx);
      int unsigned gap;
      if (!calm_stretch && $urandom_range(99) < 4) begin
         gap = $urandom_range(1, 3);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_pin_level   <= pin;
      req_timer_value <= stamp;
      req_read_index  <= idx;
      do @(posedge clock); while (!req_ready);
      offered_beats++;
   endtask

   // The fields an operation does not use carry random values throughout.
   task automatic send_edge(input logic pin, input logic [23:0] stamp);
      send_beat(OP_EDGE, pin, stamp, 8'($urandom));
   endtask

   task automatic send_read(input logic [7:0] idx);
      send_beat(OP_READ, 1'($urandom), 24'($urandom), idx);
   endtask

   task automatic send_ctrl(input logic [1:0] op);
      send_beat(op, 1'($urandom), 24'($urandom), 8'($urandom));
   endtask

   // One capture session: arm, a train of edges with mostly rising timestamps,
   // a few reads of what was recorded, and usually a close. A sloppy train now
   // and then repeats an edge kind or slips a read in between edges.
   task automatic pulse_train(input int unsigned n_edges, input bit sloppy);
      logic [23:0] stamp;
      logic        pin;
      int unsigned k;
      int unsigned top;
      stamp = 24'($urandom);
      pin   = ($urandom_range(7) == 0) ? PIN_RISE : PIN_FALL;
      send_ctrl(OP_ARM);
      for (k = 0; k < n_edges; k++) begin
         case ($urandom_range(19))
            0:       stamp = 24'($urandom);
            1:       stamp = stamp + 24'($urandom_range(0, 49));
            2:       stamp = stamp + 24'($urandom_range(3000000, 16000000));
            default: stamp = stamp + 24'($urandom_range(50, 300000));
         endcase
         send_edge(pin, stamp);
         if (!(sloppy && $urandom_range(11) == 0))
            pin = ~pin;
         if (sloppy && $urandom_range(14) == 0)
            send_read(8'($urandom_range(0, k)));
      end
      top = (n_edges + 1 > 255) ? 255 : n_edges + 1;
      repeat ($urandom_range(1, 6)) begin
         if ($urandom_range(4) == 0)
            send_read(8'($urandom));
         else
            send_read(8'($urandom_range(0, top)));
      end
      if ($urandom_range(3) != 0)
         send_ctrl(OP_CLOSE);
   endtask

   // Fully random beats: edges while closed, stray closes, arbitrary reads.
   task automatic send_noise(input int unsigned n);
      repeat (n)
         send_beat(2'($urandom), 1'($urandom), 24'($urandom), 8'($urandom));
   endtask

   initial begin
      int unsigned random_start;
      int unsigned train_no;

      // Synchronous reset held at the start, then released for good.
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed opening.
      send_read(8'd0);                    // empty store: read comes back invalid
      send_edge(PIN_RISE, 24'h123456);    // edge while capture is off is ignored
      send_ctrl(OP_CLOSE);                // close while already closed
      send_ctrl(OP_ARM);
      send_edge(PIN_RISE, 24'h000100);    // rise before any fall only sets flags
      send_edge(PIN_FALL, 24'hFFFFF0);    // first fall sets the reference time
      send_edge(PIN_FALL, 24'h000005);    // repeated fall: no append, no update
      send_edge(PIN_RISE, 24'h000010);    // timer wrapped between fall and rise
      send_edge(PIN_RISE, 24'h400000);    // repeated rise
      send_edge(PIN_FALL, 24'hFFFFFF);    // long high level at the timer maximum
      send_edge(PIN_RISE, 24'h000000);    // timer at zero
      send_read(8'd0);
      send_read(8'd1);
      send_read(8'd2);
      send_read(8'd255);                  // far beyond the entry count
      send_edge(PIN_FALL, 24'h0ABCDE);
      send_ctrl(OP_ARM);                  // re-arm while capture is running
      send_edge(PIN_RISE, 24'h0B0000);    // rise while waiting for the first
                                          // fall appends off the old fall time
      send_edge(PIN_FALL, 24'h0C0000);    // still waiting: reference only
      send_edge(PIN_RISE, 24'h0C1000);
      send_ctrl(OP_CLOSE);
      send_edge(PIN_FALL, 24'h0C2000);    // ignored after close
      send_read(8'd0);
      send_read(8'd2);                    // index equal to the count

      // Random part. Two long trains overflow the store so that dropped
      // appends and reads of the top entries are covered.
      random_start = offered_beats;
      train_no     = 0;
      while (offered_beats - random_start < ITEM_TARGET) begin
         if (train_no == 2 || train_no == 9)
            pulse_train(270, train_no == 9);
         else if ($urandom_range(99) < 80)
            pulse_train($urandom_range(1, 40), 1'($urandom));
         else
            send_noise($urandom_range(1, 10));
         train_no++;
      end
      @(negedge clock);
      req_valid <= 1'b0;

      // Wait for every outstanding response, then give the pipeline time to
      // show any response it should not produce.
      while (sb.awaited_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d request beats in %0d random sequences: %0d appends, %0d",
               accepted_beats, train_no, sb.appends, sb.dropped);
      $display("appends dropped on a full store, %0d reads that hit, %0d mismatches.",
               sb.read_hits, sb.mismatches);
      if (sb.mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
